// File: hw/rtl/bsm_pkg.sv
// Shared constants and types for the supply channel monitor.
package bsm_pkg;

  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int GAIN_Q16   = 328;
  localparam int GAIN_W     = 9;
  localparam int GAIN_SHIFT = 16;

  localparam int UVLO_RESET  = 1552;
  localparam int HYST_RESET  = 78;
  localparam int STEP_RESET  = 388;
  localparam int ILIM_RESET  = 2062;

  typedef enum logic [1:0] {
    REG_UVLO = 2'd0,
    REG_HYST = 2'd1,
    REG_STEP = 2'd2,
    REG_ILIM = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_CHECK  = 1'b1
  } action_t;

endpackage

// File: hw/rtl/bsm_cfg_regs.sv
// APB configuration registers for the supply channel monitor.
module bsm_cfg_regs
  import bsm_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  output logic [SAMPLE_BITS-1:0] uvlo_code,
  output logic [SAMPLE_BITS-1:0] hyst_code,
  output logic [SAMPLE_BITS-1:0] step_code,
  output logic [SAMPLE_BITS-1:0] current_limit_code
);

  logic [SAMPLE_BITS-1:0] uvlo_r, hyst_r, step_r, ilim_r;
  logic                   wr_en;
  cfg_reg_t               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uvlo_r <= SAMPLE_BITS'(UVLO_RESET);
      hyst_r <= SAMPLE_BITS'(HYST_RESET);
      step_r <= SAMPLE_BITS'(STEP_RESET);
      ilim_r <= SAMPLE_BITS'(ILIM_RESET);
    end else if (wr_en) begin
      case (reg_sel)
        REG_UVLO: uvlo_r <= pwdata[SAMPLE_BITS-1:0];
        REG_HYST: hyst_r <= pwdata[SAMPLE_BITS-1:0];
        REG_STEP: step_r <= pwdata[SAMPLE_BITS-1:0];
        REG_ILIM: ilim_r <= pwdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_UVLO: prdata = DATA_W'(uvlo_r);
      REG_HYST: prdata = DATA_W'(hyst_r);
      REG_STEP: prdata = DATA_W'(step_r);
      REG_ILIM: prdata = DATA_W'(ilim_r);
      default:  prdata = '0;
    endcase
  end

  assign uvlo_code          = uvlo_r;
  assign hyst_code          = hyst_r;
  assign step_code          = step_r;
  assign current_limit_code = ilim_r;

endmodule

// File: hw/rtl/battery_source_monitor.sv
// Top level of the supply channel monitor: low-pass level and attach/charge status.
// A request is captured in the input register and then its result in the result register.
// Throughput: one request per cycle unless out_ready stalls; the per-channel state
// read, filter update and write-back complete in the single stage between those registers.
// Reset (synchronous, active low) clears all channel state and both stage valids,
// and loads the register defaults.
module battery_source_monitor
  import bsm_pkg::*;
#(
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [1:0]                    in_channel,
  input  logic [SAMPLE_BITS-1:0]        in_sample_code,
  input  logic [SAMPLE_BITS-1:0]        in_current_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_channel,
  output logic                          out_attached,
  output logic                          out_charged,
  output logic [SAMPLE_BITS-1:0]        out_level_code,
  output logic signed [SAMPLE_BITS:0]   out_step_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W = (CH_W > 2) ? CH_W : 2;
  localparam int LPF_W = SAMPLE_BITS + FRAC_BITS;
  localparam int D_W   = LPF_W + 1;
  localparam int P_W   = D_W + GAIN_W + 1;

  logic [SAMPLE_BITS-1:0] uvlo_code, hyst_code, step_code, ilim_code;

  bsm_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .uvlo_code          (uvlo_code),
    .hyst_code          (hyst_code),
    .step_code          (step_code),
    .current_limit_code (ilim_code)
  );

  // input stage
  logic                   s1_valid_r;
  action_t                s1_action_r;
  logic [1:0]             s1_channel_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r, s1_current_r;
  logic                   s1_adv;

  // channel state
  logic [LPF_W-1:0]       lpf_r      [CHANNELS];
  logic [SAMPLE_BITS-1:0] last_r     [CHANNELS];
  logic [CHANNELS-1:0]    attached_r;
  logic [CHANNELS-1:0]    charged_r;

  // result stage
  logic                   out_valid_r;
  logic [1:0]             out_channel_r;
  logic                   out_attached_r, out_charged_r;
  logic [SAMPLE_BITS-1:0] out_level_r;
  logic [SAMPLE_BITS:0]   out_step_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r  <= action_t'(in_action);
      s1_channel_r <= in_channel;
      s1_sample_r  <= in_sample_code;
      s1_current_r <= in_current_code;
    end
  end

  // state read
  logic [EXT_W-1:0]       ch_ext;
  logic [CH_W-1:0]        idx;
  logic                   ch_ok;
  logic [LPF_W-1:0]       cur_lpf;
  logic [SAMPLE_BITS-1:0] cur_last;
  logic                   cur_att, cur_chg;

  assign ch_ext = EXT_W'(s1_channel_r);
  assign idx    = ch_ext[CH_W-1:0];
  assign ch_ok  = 32'(ch_ext) < CHANNELS;

  always_comb begin
    cur_lpf  = '0;
    cur_last = '0;
    cur_att  = 1'b0;
    cur_chg  = 1'b0;
    if (ch_ok) begin
      cur_lpf  = lpf_r[idx];
      cur_last = last_r[idx];
      cur_att  = attached_r[idx];
      cur_chg  = charged_r[idx];
    end
  end

  // sample path: lpf += floor((target - lpf) * gain / 2^16)
  logic [LPF_W-1:0]        target;
  logic signed [D_W-1:0]   diff;
  logic signed [P_W-1:0]   prod;
  logic signed [P_W-1:0]   prod_sh;
  logic [LPF_W-1:0]        lpf_smp;

  assign target  = LPF_W'(s1_sample_r) << FRAC_BITS;
  assign diff    = $signed({1'b0, target}) - $signed({1'b0, cur_lpf});
  assign prod    = P_W'(diff) * P_W'($signed({1'b0, GAIN_W'(GAIN_Q16)}));
  assign prod_sh = prod >>> GAIN_SHIFT;
  assign lpf_smp = cur_lpf + prod_sh[LPF_W-1:0];

  // check path
  logic [LPF_W-1:0]        raw_fx;
  logic signed [D_W-1:0]   hpf, thr, thr_neg;
  logic                    neg_step, pos_step;
  logic [LPF_W-1:0]        lpf_chk, lo_lim;
  logic [LPF_W:0]          hi_lim;
  logic                    att_chk, chg_chk;

  assign raw_fx   = LPF_W'(cur_last) << FRAC_BITS;
  assign hpf      = $signed({1'b0, raw_fx}) - $signed({1'b0, cur_lpf});
  assign thr      = $signed({1'b0, LPF_W'(step_code) << FRAC_BITS});
  assign thr_neg  = -thr;
  assign neg_step = hpf < thr_neg;
  assign pos_step = hpf > thr;
  assign lo_lim   = LPF_W'(uvlo_code) << FRAC_BITS;
  assign hi_lim   = (LPF_W + 1)'({1'b0, uvlo_code} + {1'b0, hyst_code}) << FRAC_BITS;

  always_comb begin
    lpf_chk = cur_lpf;
    att_chk = cur_att;
    if (neg_step) begin
      if (s1_current_r < ilim_code) begin
        lpf_chk = '0;
        att_chk = 1'b0;
      end
    end else if (pos_step) begin
      lpf_chk = raw_fx;
      att_chk = 1'b1;
    end
    chg_chk = cur_chg;
    if (lpf_chk < lo_lim) begin
      chg_chk = 1'b0;
    end else if ((LPF_W + 1)'(lpf_chk) > hi_lim) begin
      chg_chk = 1'b1;
    end
  end

  // next state and result
  logic [LPF_W-1:0]       lpf_nxt;
  logic [SAMPLE_BITS-1:0] last_nxt;
  logic                   att_nxt, chg_nxt;
  logic [SAMPLE_BITS-1:0] level_nxt;
  logic [SAMPLE_BITS:0]   step_nxt;

  always_comb begin
    case (s1_action_r)
      ACT_SAMPLE: begin
        lpf_nxt  = lpf_smp;
        last_nxt = s1_sample_r;
        att_nxt  = cur_att;
        chg_nxt  = cur_chg;
      end
      default: begin
        lpf_nxt  = lpf_chk;
        last_nxt = cur_last;
        att_nxt  = att_chk;
        chg_nxt  = chg_chk;
      end
    endcase
  end

  assign level_nxt = lpf_nxt[LPF_W-1:FRAC_BITS];
  assign step_nxt  = {1'b0, last_nxt} - {1'b0, level_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lpf_r[i]  <= '0;
        last_r[i] <= '0;
      end
      attached_r <= '0;
      charged_r  <= '0;
    end else if (s1_adv && ch_ok) begin
      lpf_r[idx]      <= lpf_nxt;
      last_r[idx]     <= last_nxt;
      attached_r[idx] <= att_nxt;
      charged_r[idx]  <= chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_channel_r  <= s1_channel_r;
      out_attached_r <= ch_ok ? att_nxt : 1'b0;
      out_charged_r  <= ch_ok ? chg_nxt : 1'b0;
      out_level_r    <= ch_ok ? level_nxt : '0;
      out_step_r     <= ch_ok ? step_nxt : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_channel_r;
  assign out_attached   = out_attached_r;
  assign out_charged    = out_charged_r;
  assign out_level_code = out_level_r;
  assign out_step_value = $signed(out_step_r);

endmodule

// File: tb/battery_source_monitor_tb.sv
// Testbench for battery_source_monitor: predicts every channel status result and checks it.
`timescale 1ns / 100ps

module battery_source_monitor_tb
  import bsm_pkg::*;
();

  localparam int FRAC   = 16;
  localparam int CODE_W = 12;

  typedef struct packed {
    logic [1:0]        ch;
    logic              attached;
    logic              charged;
    logic [CODE_W-1:0] level;
    logic [CODE_W:0]   step;
  } status_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_action = 1'b0;
  logic [1:0]               in_channel = '0;
  logic [CODE_W-1:0]        in_sample_code = '0;
  logic [CODE_W-1:0]        in_current_code = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_channel;
  logic                     out_attached;
  logic                     out_charged;
  logic [CODE_W-1:0]        out_level_code;
  logic signed [CODE_W:0]   out_step_value;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // model of the channel state and registers
  logic [27:0]       lpf_q [4];
  logic [CODE_W-1:0] last_code [4];
  logic              attached_st [4];
  logic              charged_st [4];
  logic [CODE_W-1:0] uvlo_q = CODE_W'(UVLO_RESET);
  logic [CODE_W-1:0] hyst_q = CODE_W'(HYST_RESET);
  logic [CODE_W-1:0] step_q = CODE_W'(STEP_RESET);
  logic [CODE_W-1:0] ilim_q = CODE_W'(ILIM_RESET);

  status_t expected_status[$];
  int      err_count = 0;
  int      sent_count = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_left = 0;

  battery_source_monitor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_channel      (in_channel),
    .in_sample_code  (in_sample_code),
    .in_current_code (in_current_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_attached    (out_attached),
    .out_charged     (out_charged),
    .out_level_code  (out_level_code),
    .out_step_value  (out_step_value),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      lpf_q[i] = '0;
      last_code[i] = '0;
      attached_st[i] = 1'b0;
      charged_st[i] = 1'b0;
    end
  end

  function automatic status_t predict_status(action_t act, logic [1:0] ch,
                                             logic [CODE_W-1:0] smp,
                                             logic [CODE_W-1:0] cur);
    longint  lpf;
    longint  raw;
    longint  hpf;
    longint  thr;
    status_t st;
    lpf = longint'(lpf_q[ch]);
    if (act == ACT_SAMPLE) begin
      last_code[ch] = smp;
      raw = longint'(smp) << FRAC;
      lpf = lpf + (((raw - lpf) * GAIN_Q16) >>> GAIN_SHIFT);
      lpf_q[ch] = lpf[27:0];
    end else begin
      raw = longint'(last_code[ch]) << FRAC;
      hpf = raw - lpf;
      thr = longint'(step_q) << FRAC;
      if (hpf < -thr) begin
        if (cur < ilim_q) begin
          attached_st[ch] = 1'b0;
          lpf = 0;
        end
      end else if (hpf > thr) begin
        attached_st[ch] = 1'b1;
        lpf = raw;
      end
      lpf_q[ch] = lpf[27:0];
      if (longint'(lpf_q[ch]) < (longint'(uvlo_q) << FRAC)) begin
        charged_st[ch] = 1'b0;
      end else if (longint'(lpf_q[ch]) > ((longint'(uvlo_q) + longint'(hyst_q)) << FRAC)) begin
        charged_st[ch] = 1'b1;
      end
    end
    st.ch       = ch;
    st.attached = attached_st[ch];
    st.charged  = charged_st[ch];
    st.level    = lpf_q[ch][27:16];
    st.step     = {1'b0, last_code[ch]} - {1'b0, st.level};
    return st;
  endfunction

  function automatic logic [CODE_W-1:0] clamp_code(int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return CODE_W'(v);
  endfunction

  // result side: random stalls, long hold-offs on request, and checking
  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $error("unexpected result on channel %0d", out_channel);
        err_count++;
      end else begin
        want = expected_status.pop_front();
        if (out_channel !== want.ch) begin
          $error("out_channel: expected %0d, actual %0d", want.ch, out_channel);
          err_count++;
        end
        if (out_attached !== want.attached) begin
          $error("attached: expected %0d, actual %0d", want.attached, out_attached);
          err_count++;
        end
        if (out_charged !== want.charged) begin
          $error("charged: expected %0d, actual %0d", want.charged, out_charged);
          err_count++;
        end
        if (out_level_code !== want.level) begin
          $error("level_code: expected %0d, actual %0d", want.level, out_level_code);
          err_count++;
        end
        if (out_step_value !== want.step) begin
          $error("step_value: expected %0d, actual %0d", $signed(want.step), out_step_value);
          err_count++;
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_request(action_t act, logic [1:0] ch, logic [CODE_W-1:0] smp,
                              logic [CODE_W-1:0] cur);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_channel      <= ch;
    in_sample_code  <= smp;
    in_current_code <= cur;
    do @(posedge clk); while (!in_ready);
    expected_status.push_back(predict_status(act, ch, smp, cur));
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write followed by a read-back; called on a clock edge with the block idle
  task automatic write_reg(cfg_reg_t r, logic [CODE_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {($urandom_range(0, 1) ? 20'($urandom()) : 20'd0), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_UVLO: uvlo_q = v;
      REG_HYST: hyst_q = v;
      REG_STEP: step_q = v;
      REG_ILIM: ilim_q = v;
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CODE_W-1:0] !== v) begin
      $error("register %s: expected %0d, actual %0d", r.name(), v, prdata[CODE_W-1:0]);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_config(logic [CODE_W-1:0] uvlo, logic [CODE_W-1:0] hyst,
                             logic [CODE_W-1:0] step, logic [CODE_W-1:0] ilim);
    write_reg(REG_UVLO, uvlo);
    write_reg(REG_HYST, hyst);
    write_reg(REG_STEP, step);
    write_reg(REG_ILIM, ilim);
    @(posedge clk);
  endtask

  // samples around a chosen level on one channel, then one or two checks
  task automatic send_burst();
    logic [1:0]        ch;
    int                base;
    int                lvl;
    int                d;
    logic [CODE_W-1:0] cur;
    ch  = 2'($urandom_range(0, 3));
    lvl = int'(lpf_q[ch][27:16]);
    case ($urandom_range(0, 3))
      0: base = $urandom_range(0, 4095);
      1: base = int'(uvlo_q) + $urandom_range(0, int'(hyst_q) + 40) - 20;
      2: base = $urandom_range(0, 1) ? 4095 : 0;
      default: begin
        d = int'(step_q) + $urandom_range(0, 6) - 3;
        base = $urandom_range(0, 1) ? lvl + d : lvl - d;
      end
    endcase
    repeat ($urandom_range(1, 6)) begin
      send_request(ACT_SAMPLE, ch, clamp_code(base + $urandom_range(0, 4) - 2),
                   12'($urandom()));
    end
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 3))
        0: cur = ilim_q;
        1: cur = ilim_q - 12'd1;
        default: cur = 12'($urandom());
      endcase
      send_request(ACT_CHECK, ch, 12'($urandom()), cur);
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_request(ACT_SAMPLE, 2'd0, 12'd4095, 12'd0);
    send_request(ACT_SAMPLE, 2'd1, 12'd0, 12'd4095);
    send_request(ACT_CHECK,  2'd0, 12'd0, 12'd0);
    send_request(ACT_CHECK,  2'd0, 12'd0, 12'd0);
    send_request(ACT_SAMPLE, 2'd0, 12'd0, 12'd0);
    send_request(ACT_CHECK,  2'd0, 12'd0, 12'd4095);
    send_request(ACT_CHECK,  2'd0, 12'd0, 12'd2062);
    send_request(ACT_CHECK,  2'd0, 12'd0, 12'd2061);
    send_request(ACT_CHECK,  2'd0, 12'd0, 12'd0);
    send_request(ACT_CHECK,  2'd1, 12'd4095, 12'd0);
    send_request(ACT_SAMPLE, 2'd2, 12'd1580, 12'd0);
    send_request(ACT_CHECK,  2'd2, 12'd0, 12'd0);
    send_request(ACT_SAMPLE, 2'd2, 12'd2000, 12'd0);
    send_request(ACT_CHECK,  2'd2, 12'd0, 12'd0);
    send_request(ACT_SAMPLE, 2'd2, 12'd1580, 12'd0);
    send_request(ACT_CHECK,  2'd2, 12'd0, 12'd4095);
    send_request(ACT_SAMPLE, 2'd3, 12'd388, 12'd0);
    send_request(ACT_CHECK,  2'd3, 12'd0, 12'd0);
    send_request(ACT_SAMPLE, 2'd3, 12'd4095, 12'd4095);
    send_request(ACT_CHECK,  2'd3, 12'd4095, 12'd4095);
    send_request(ACT_SAMPLE, 2'd1, 12'd4095, 12'd4095);
    send_request(ACT_CHECK,  2'd1, 12'd4095, 12'd4095);
    drain_results();
  endtask

  // receiver holds off while requests keep coming, then the sender waits for all results
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 150;
    repeat (30) begin
      send_request(action_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   12'($urandom()), 12'($urandom()));
    end
    drain_results();
  endtask

  task automatic test_random_traffic(int n_items, int s_idle, int r_idle);
    int stop_at;
    send_idle_pct = s_idle;
    stall_pct = r_idle;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        send_request(action_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     12'($urandom()), 12'($urandom()));
      end else begin
        send_burst();
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_traffic(200, 0, 0);
    test_config(12'd0, 12'd0, 12'd0, 12'd4095);
    test_random_traffic(150, 83, 0);
    test_config(12'd4095, 12'd4095, 12'd4095, 12'd0);
    test_random_traffic(150, 0, 83);
    test_config(12'($urandom_range(1200, 2000)), 12'($urandom_range(0, 200)),
                12'($urandom_range(50, 800)), 12'($urandom()));
    test_random_traffic(200, 29, 29);
    test_config(12'($urandom()), 12'($urandom()), 12'($urandom_range(0, 1000)),
                12'($urandom()));
    test_random_traffic(200, 0, 0);
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
